@@ hw/rtl/lpr_pkg.sv @@
// Shared constants, types and helpers for the length-prefixed packet ring.
package lpr_pkg;

   localparam int BUF_DEPTH = 65536;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);
   localparam int LEN_W     = 16;
   localparam int BYTE_W    = 8;

   typedef logic [ADDR_W-1:0] ptr_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [1:0] {
      ST_WR_OK    = 2'd0,
      ST_WR_REJ   = 2'd1,
      ST_RD_OK    = 2'd2,
      ST_RD_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic     we;
      ptr_type  waddr;
      byte_type wdata;
      ptr_type  raddr;
   } mem_req_type;

   typedef struct packed {
      len_type free_bytes;
      logic    room;
   } space_type;

   function automatic ptr_type ring_next(ptr_type p);
      ring_next = (p == ptr_type'(BUF_DEPTH - 1)) ? '0 : p + ptr_type'(1);
   endfunction

endpackage

@@ hw/rtl/lpr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module lpr_ram #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/lpr_space.sv @@
// Free-space count of the ring and the room check for a new packet.
module lpr_space import lpr_pkg::*; (
   input  ptr_type   write_ptr,
   input  ptr_type   read_ptr,
   input  len_type   packet_length,
   output space_type space
);

   localparam logic [ADDR_W:0] DEPTH_V = (ADDR_W + 1)'(BUF_DEPTH);

   logic [ADDR_W:0] used;
   logic [ADDR_W:0] free_cnt;
   logic [LEN_W:0]  need;

   always_comb begin
      if (write_ptr >= read_ptr) begin
         used = {1'b0, write_ptr} - {1'b0, read_ptr};
      end else begin
         used = {1'b0, write_ptr} + DEPTH_V - {1'b0, read_ptr};
      end
      free_cnt = DEPTH_V - (ADDR_W + 1)'(1) - used;
      // header takes two bytes on top of the payload
      need     = {1'b0, packet_length} + (LEN_W + 1)'(2);
      space.free_bytes = LEN_W'(free_cnt);
      space.room       = (LEN_W + 1)'(free_cnt) >= need;
   end

endmodule

@@ hw/rtl/length_prefixed_packet_ring.sv @@
// Top level of the length-prefixed packet ring: sequencer, pointers and RAM.
//
// Channel   Ports                          Transfer when
// request   start/busy, req_*              start high and busy low at the edge
// response  rsp_valid, rsp_*               rsp_valid high (one cycle, no stall)
//
// Steps per request, one RAM write port and one read port setting the pace:
//   write of a later packet byte, rejected write, empty read: done on accept
//   write of a first packet byte that fits: header low, header high, then data
//   read in a packet: address, then byte; read opening a header: low, high, byte
// The response strobes in the cycle after the last work cycle; busy is already
// low then, so the next request may be taken in the strobe cycle.
// Reset clears the pointers and counters at once; the byte RAM is not cleared
// since only bytes of committed packets are ever read. The receiver cannot
// stall, so no response buffering is needed.
module length_prefixed_packet_ring import lpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_mode,
   input  byte_type   req_data_byte,
   input  len_type    req_packet_length,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output byte_type   rsp_read_byte,
   output len_type    rsp_read_length,
   output logic       rsp_read_last,
   output len_type    rsp_free_bytes
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WR_HI,
      S_WR_DATA,
      S_RD_LO,
      S_RD_HI,
      S_RD_BYTE
   } state_type;

   state_type  state_ff, state_in;

   // ring pointers and packet counters
   ptr_type    commit_ff, commit_in;
   ptr_type    rtail_ff, rtail_in;
   ptr_type    wptr_ff, wptr_in;
   len_type    wrem_ff, wrem_in;
   logic       disc_ff, disc_in;
   len_type    rrem_ff, rrem_in;
   len_type    rlen_ff, rlen_in;

   // request payload held across a multi-cycle write, header low byte on read
   byte_type   data_ff, data_in;
   len_type    plen_ff, plen_in;
   byte_type   lo_ff, lo_in;

   // response registers
   logic       rvalid_ff, rvalid_in;
   status_type rstat_ff, rstat_in;
   byte_type   rbyte_ff, rbyte_in;
   len_type    olen_ff, olen_in;
   logic       rlast_ff, rlast_in;

   mem_req_type mem_req;
   byte_type    rdata;
   space_type   space;
   len_type     hdr_len;
   logic        accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   lpr_space u_space (
      .write_ptr     (wptr_ff),
      .read_ptr      (rtail_ff),
      .packet_length (req_packet_length),
      .space         (space)
   );

   lpr_ram #(
      .DEPTH (BUF_DEPTH),
      .WIDTH (BYTE_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (rdata)
   );

   always_comb begin
      state_in  = state_ff;
      commit_in = commit_ff;
      rtail_in  = rtail_ff;
      wptr_in   = wptr_ff;
      wrem_in   = wrem_ff;
      disc_in   = disc_ff;
      rrem_in   = rrem_ff;
      rlen_in   = rlen_ff;
      data_in   = data_ff;
      plen_in   = plen_ff;
      lo_in     = lo_ff;
      rvalid_in = 1'b0;
      rstat_in  = rstat_ff;
      rbyte_in  = '0;
      olen_in   = '0;
      rlast_in  = 1'b0;
      hdr_len   = {rdata, lo_ff};
      mem_req   = '{we: 1'b0, waddr: wptr_ff, wdata: data_ff, raddr: rtail_ff};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               data_in = req_data_byte;
               plen_in = req_packet_length;
               if (req_mode == 1'b0) begin
                  if (wrem_ff == '0) begin
                     if (req_packet_length == '0 || !space.room) begin
                        // whole packet dropped; count off its later bytes
                        rvalid_in = 1'b1;
                        rstat_in  = ST_WR_REJ;
                        wrem_in   = (req_packet_length == '0) ? '0
                                    : req_packet_length - len_type'(1);
                        disc_in   = (req_packet_length > len_type'(1));
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = req_packet_length[7:0];
                        wptr_in       = ring_next(wptr_ff);
                        state_in      = S_WR_HI;
                     end
                  end else if (disc_ff) begin
                     rvalid_in = 1'b1;
                     rstat_in  = ST_WR_REJ;
                     wrem_in   = wrem_ff - len_type'(1);
                     if (wrem_ff == len_type'(1)) begin
                        disc_in = 1'b0;
                     end
                  end else begin
                     mem_req.we    = 1'b1;
                     mem_req.wdata = req_data_byte;
                     wptr_in       = ring_next(wptr_ff);
                     wrem_in       = wrem_ff - len_type'(1);
                     if (wrem_ff == len_type'(1)) begin
                        commit_in = ring_next(wptr_ff);
                     end
                     rvalid_in = 1'b1;
                     rstat_in  = ST_WR_OK;
                  end
               end else begin
                  if (rrem_ff == '0 && commit_ff != rtail_ff) begin
                     rtail_in = ring_next(rtail_ff);
                     state_in = S_RD_LO;
                  end else if (rrem_ff != '0) begin
                     rtail_in = ring_next(rtail_ff);
                     state_in = S_RD_BYTE;
                  end else begin
                     rvalid_in = 1'b1;
                     rstat_in  = ST_RD_EMPTY;
                  end
               end
            end
         end
         S_WR_HI: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = plen_ff[15:8];
            wptr_in       = ring_next(wptr_ff);
            state_in      = S_WR_DATA;
         end
         S_WR_DATA: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = data_ff;
            wptr_in       = ring_next(wptr_ff);
            wrem_in       = plen_ff - len_type'(1);
            disc_in       = 1'b0;
            if (plen_ff == len_type'(1)) begin
               commit_in = ring_next(wptr_ff);
            end
            rvalid_in = 1'b1;
            rstat_in  = ST_WR_OK;
            state_in  = S_IDLE;
         end
         S_RD_LO: begin
            lo_in    = rdata;
            rtail_in = ring_next(rtail_ff);
            state_in = S_RD_HI;
         end
         S_RD_HI: begin
            rlen_in = hdr_len;
            rrem_in = hdr_len;
            if (hdr_len != '0) begin
               rtail_in = ring_next(rtail_ff);
               state_in = S_RD_BYTE;
            end else begin
               // empty header is never stored, but consume it cleanly
               rvalid_in = 1'b1;
               rstat_in  = ST_RD_EMPTY;
               state_in  = S_IDLE;
            end
         end
         S_RD_BYTE: begin
            rrem_in   = rrem_ff - len_type'(1);
            rvalid_in = 1'b1;
            rstat_in  = ST_RD_OK;
            rbyte_in  = rdata;
            olen_in   = rlen_ff;
            rlast_in  = (rrem_ff == len_type'(1));
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         commit_ff <= '0;
         rtail_ff  <= '0;
         wptr_ff   <= '0;
         wrem_ff   <= '0;
         disc_ff   <= 1'b0;
         rrem_ff   <= '0;
         rlen_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         commit_ff <= commit_in;
         rtail_ff  <= rtail_in;
         wptr_ff   <= wptr_in;
         wrem_ff   <= wrem_in;
         disc_ff   <= disc_in;
         rrem_ff   <= rrem_in;
         rlen_ff   <= rlen_in;
         rvalid_ff <= rvalid_in;
      end
      data_ff  <= data_in;
      plen_ff  <= plen_in;
      lo_ff    <= lo_in;
      rstat_ff <= rstat_in;
      rbyte_ff <= rbyte_in;
      olen_ff  <= olen_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_status      = rstat_ff;
   assign rsp_read_byte   = rbyte_ff;
   assign rsp_read_length = olen_ff;
   assign rsp_read_last   = rlast_ff;
   // pointers already hold the post-transfer values in the strobe cycle
   assign rsp_free_bytes  = space.free_bytes;

endmodule

@@ hw/rtl/lpr_checker.sv @@
// Port-level checks for the packet ring, bound to the top level.
module lpr_checker import lpr_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input byte_type   rsp_read_byte,
   input len_type    rsp_read_length,
   input logic       rsp_read_last,
   input len_type    rsp_free_bytes
);

   // every accepted request either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor in progress");

   // busy only starts on an accepted request
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // read fields are zero unless a byte was read
   a_read_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_RD_OK) |->
         (rsp_read_byte == '0 && rsp_read_length == '0 && !rsp_read_last))
      else $error("read fields set without a read byte");

   // a rejected write leaves the free count unchanged
   a_reject_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_WR_REJ) |->
         (rsp_free_bytes == $past(rsp_free_bytes)))
      else $error("rejected write changed free space");

endmodule

bind length_prefixed_packet_ring lpr_checker u_lpr_checker (.*);
